// ===== rtl/core/icmp_echo_encapsulator_top_assert.svh =====
// Assertion macros shared by the ICMP echo encapsulator RTL.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef ICMP_ECHO_ENCAPSULATOR_TOP_ASSERT_SVH
`define ICMP_ECHO_ENCAPSULATOR_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define ICMP_ENC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("icmp_enc: assertion failed");

// Check a property on every clock edge, reset included.
`define ICMP_ENC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("icmp_enc: assertion failed");

`endif

// ===== rtl/core/icmp_enc_pkg.sv =====
// Shared types and constants for the ICMP echo encapsulator.
// No dependencies; used by the interfaces and every module of the block.
package icmp_enc_pkg;

  localparam int unsigned LEN_W = 17;
  localparam logic [LEN_W-1:0] MAX_PAYLOAD = 17'd65507;
  localparam logic [LEN_W-1:0] LEN_CAP = 17'd65508;
  localparam logic [15:0] HEADER_BYTES = 16'd28;
  localparam logic [2:0] LAST_IDX = 3'd6;

  localparam logic [15:0] IP_VER_TOS = 16'h4500;
  localparam logic [15:0] IP_TTL_PROTO = 16'hFF01;
  localparam logic [15:0] ICMP_TYPE_CODE = 16'h0800;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SRC_ADDR  = 2'd0,
    REG_DST_ADDR  = 2'd1,
    REG_ECHO_IDENT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] echo_ident;
  } cfg_regs_t;

  // Per-packet summary handed from front to back
  typedef struct packed {
    logic [15:0] csum;
    logic [15:0] total;
    logic        over;
    logic [15:0] id;
  } pkt_desc_t;

endpackage

// ===== rtl/core/icmp_enc_ifs.sv =====
// Channel interfaces of the ICMP echo encapsulator: payload in, header out,
// configuration writes. Depends on icmp_enc_pkg.
interface icmp_enc_in_if import icmp_enc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [31:0] payload_word;
  logic [2:0]  word_bytes;
  logic        last_word;
  modport source(output valid, payload_word, word_bytes, last_word, input ready);
  modport sink(input valid, payload_word, word_bytes, last_word, output ready);
endinterface

interface icmp_enc_out_if import icmp_enc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [31:0] header_word;
  logic [2:0]  word_index;
  logic        last_header;
  logic        oversize;
  modport source(output valid, header_word, word_index, last_header, oversize,
                 input ready);
  modport sink(input valid, header_word, word_index, last_header, oversize,
               output ready);
endinterface

interface icmp_enc_cfg_if import icmp_enc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/icmp_echo_encapsulator_top.sv =====
// ICMP echo request encapsulator, IPv4: block top level.
// Payload channel in, header channel out, configuration write channel.
// Depends on icmp_enc_pkg, the channel interfaces, front, queue and back.
//
// Usage: stream payload words on the payload channel, first byte in bits
// 31:24, word_bytes giving the valid bytes (only the last word short).
// On the word marked last_word the block emits seven header words on the
// header channel (20-byte IPv4 header, then 8-byte ICMP echo header).
// Throughput: one payload word per cycle while the queue is not full; the
// back end sends one header word per cycle while the receiver is ready.
// With the back end free, the summary of the last payload word passes the
// queue, register cur and the output register before the first header is valid.
// A two-entry summary queue lets the front keep taking payload while the
// back end drains; payload ready drops only when the queue is full.
// A header receiver stall holds the output register and back end, and
// after the queue fills, the payload channel.
// Reset clears the checksum, length and queue, sets the datagram id to 1
// and the addresses and identifier to 0. The config channel is always
// ready; write it only while the block is idle.
module icmp_echo_encapsulator_top import icmp_enc_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  icmp_enc_in_if.sink    payload,
  icmp_enc_out_if.source header,
  icmp_enc_cfg_if.sink   cfg
);

  cfg_regs_t cfg_regs;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_empty;
  pkt_desc_t push_desc;
  pkt_desc_t pop_desc;

  assign cfg.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid) begin
      case (cfg_reg_e'(cfg.index))
        REG_SRC_ADDR: cfg_regs.src_addr <= cfg.data;
        REG_DST_ADDR: cfg_regs.dst_addr <= cfg.data;
        REG_ECHO_IDENT: cfg_regs.echo_ident <= cfg.data[15:0];
        default: cfg_regs <= cfg_regs;
      endcase
    end
  end

  icmp_enc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .payload(payload),
    .q_full (q_full),
    .push   (push),
    .desc   (push_desc)
  );

  icmp_enc_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data(push_desc),
    .pop    (pop),
    .rd_data(pop_desc),
    .full   (q_full),
    .empty  (q_empty)
  );

  icmp_enc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg_regs(cfg_regs),
    .q_empty (q_empty),
    .q_data  (pop_desc),
    .pop     (pop),
    .header  (header)
  );

endmodule

// ===== rtl/core/icmp_enc_front.sv =====
// Front end: accepts payload words, keeps the running checksum, length and
// datagram id, and pushes one packet summary per last word. Uses icmp_enc_pkg.
`include "icmp_echo_encapsulator_top_assert.svh"

module icmp_enc_front import icmp_enc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  icmp_enc_in_if.sink       payload,
  input  logic              q_full,
  output logic              push,
  output pkt_desc_t         desc
);

  logic [15:0]      sum;
  logic [LEN_W-1:0] len;
  logic [15:0]      id;
  logic [15:0]      sum_next;
  logic [LEN_W-1:0] len_next;
  logic [15:0]      id_next;
  logic             acc;
  logic [2:0]       nb;
  logic [31:0]      word;
  logic [17:0]      s_raw;
  logic [16:0]      s_fold;
  logic [LEN_W-1:0] len_add;
  logic [LEN_W-1:0] len_sat;
  logic             over;

  assign payload.ready = !q_full;
  assign acc = payload.valid && payload.ready;

  // Clamp byte count and mask unused bytes
  always_comb begin
    nb = (payload.word_bytes > 3'd4) ? 3'd4 : payload.word_bytes;
    case (nb)
      3'd0: word = 32'h0;
      3'd1: word = payload.payload_word & 32'hFF00_0000;
      3'd2: word = payload.payload_word & 32'hFFFF_0000;
      3'd3: word = payload.payload_word & 32'hFFFF_FF00;
      default: word = payload.payload_word;
    endcase
  end

  // Ones'-complement accumulate and saturating byte count
  always_comb begin
    s_raw = {2'b00, sum} + {2'b00, word[31:16]} + {2'b00, word[15:0]};
    s_fold = {1'b0, s_raw[15:0]} + {15'd0, s_raw[17:16]};
    sum_next = s_fold[15:0] + {15'd0, s_fold[16]};
    len_add = len + {{(LEN_W-3){1'b0}}, nb};
    len_sat = (len_add > LEN_CAP) ? LEN_CAP : len_add;
    over = len_sat > MAX_PAYLOAD;
    id_next = (id == 16'hFFFF) ? 16'd1 : id + 16'd1;
  end

  // Packet summary for the back end
  assign push = acc && payload.last_word;
  always_comb begin
    desc.csum = sum_next;
    desc.total = over ? 16'hFFFF : len_sat[15:0] + HEADER_BYTES;
    desc.over = over;
    desc.id = id;
  end

  // Advance state; clear sum and length after each packet
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= 16'd0;
      len <= '0;
      id <= 16'd1;
    end else if (acc) begin
      if (payload.last_word) begin
        sum <= 16'd0;
        len <= '0;
        id <= id_next;
      end else begin
        sum <= sum_next;
        len <= len_sat;
      end
    end
  end

  `ICMP_ENC_ASSERT(a_id_nonzero, id != 16'd0)
  `ICMP_ENC_ASSERT(a_clear_after_last, push |=> (len == '0 && sum == 16'd0))
  `ICMP_ENC_ASSERT(a_over_saturates, (push && desc.over) |-> desc.total == 16'hFFFF)

endmodule

// ===== rtl/core/icmp_enc_fifo.sv =====
// Two-entry queue of packet summaries between front and back.
// Uses pkt_desc_t from icmp_enc_pkg.
module icmp_enc_fifo import icmp_enc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  pkt_desc_t wr_data,
  input  logic      pop,
  output pkt_desc_t rd_data,
  output logic      full,
  output logic      empty
);

  pkt_desc_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = count == 2'd2;
  assign empty = count == 2'd0;
  assign rd_data = mem[rd_ptr];

  // Store entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/icmp_enc_back.sv =====
// Back end: takes one packet summary at a time, forms the seven header
// words with both checksums and drives the output register. Uses icmp_enc_pkg.
`include "icmp_echo_encapsulator_top_assert.svh"

module icmp_enc_back import icmp_enc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  cfg_regs_t     cfg_regs,
  input  logic          q_empty,
  input  pkt_desc_t     q_data,
  output logic          pop,
  icmp_enc_out_if.source header
);

  pkt_desc_t   cur;
  logic        cur_valid;
  logic [2:0]  idx;
  logic        out_valid;
  logic [31:0] out_word;
  logic [2:0]  out_idx;
  logic        out_last;
  logic        out_over;
  logic        slot_free;
  logic        emit;
  logic        done;
  logic [18:0] ip_raw;
  logic [16:0] ip_fold;
  logic [15:0] ip_sum;
  logic [17:0] ic_raw;
  logic [16:0] ic_fold;
  logic [15:0] ic_sum;
  logic [31:0] word;

  assign slot_free = !out_valid || header.ready;
  assign emit = cur_valid && slot_free;
  assign done = emit && idx == LAST_IDX;
  assign pop = !q_empty && (!cur_valid || done);

  // IPv4 header checksum over the fixed and variable fields
  always_comb begin
    ip_raw = {3'd0, IP_VER_TOS} + {3'd0, cur.total} + {3'd0, cur.id}
           + {3'd0, IP_TTL_PROTO}
           + {3'd0, cfg_regs.src_addr[31:16]} + {3'd0, cfg_regs.src_addr[15:0]}
           + {3'd0, cfg_regs.dst_addr[31:16]} + {3'd0, cfg_regs.dst_addr[15:0]};
    ip_fold = {1'b0, ip_raw[15:0]} + {14'd0, ip_raw[18:16]};
    ip_sum = ip_fold[15:0] + {15'd0, ip_fold[16]};
  end

  // ICMP checksum: payload sum plus the echo header
  always_comb begin
    ic_raw = {2'd0, cur.csum} + {2'd0, ICMP_TYPE_CODE}
           + {2'd0, cfg_regs.echo_ident} + {2'd0, cur.id};
    ic_fold = {1'b0, ic_raw[15:0]} + {15'd0, ic_raw[17:16]};
    ic_sum = ic_fold[15:0] + {15'd0, ic_fold[16]};
  end

  // Select the header word for the current position
  always_comb begin
    case (idx)
      3'd0: word = {IP_VER_TOS, cur.total};
      3'd1: word = {cur.id, 16'h0000};
      3'd2: word = {IP_TTL_PROTO, ~ip_sum};
      3'd3: word = cfg_regs.src_addr;
      3'd4: word = cfg_regs.dst_addr;
      3'd5: word = {ICMP_TYPE_CODE, ~ic_sum};
      default: word = {cfg_regs.echo_ident, cur.id};
    endcase
  end

  // Load the next packet and step through its words
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx <= 3'd0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
      end else if (done) begin
        cur_valid <= 1'b0;
      end
      if (done) begin
        idx <= 3'd0;
      end else if (emit) begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word <= word;
      out_idx <= idx;
      out_last <= idx == LAST_IDX;
      out_over <= cur.over;
    end
  end

  assign header.valid = out_valid;
  assign header.header_word = out_word;
  assign header.word_index = out_idx;
  assign header.last_header = out_last;
  assign header.oversize = out_over;

  `ICMP_ENC_ASSERT(a_idx_idle, !cur_valid |-> idx == 3'd0)
  `ICMP_ENC_ASSERT(a_last_emitted, done |=> (out_valid && out_last))
  `ICMP_ENC_ASSERT(a_stall_holds_idx, (out_valid && !header.ready) |=> $stable(idx))

endmodule
